>>> sv/t0tb_pkg.sv
// Package for the T=0 TPDU byte tracker: phase and role codes, state and result structs.
// No dependencies; imported by t0tb_step and t0_tpdu_byte_tracker.
`default_nettype none

package t0tb_pkg;

   localparam int HEADER_BYTES = 5;
   localparam int POS_W        = 3;
   localparam int COUNT_W      = 9;

   localparam logic [7:0] NULL_BYTE   = 8'h60;
   localparam logic [7:0] NIBBLE_MASK = 8'hF0;
   localparam logic [7:0] SW1_NIB_6   = 8'h60;
   localparam logic [7:0] SW1_NIB_9   = 8'h90;
   localparam logic [7:0] ACK_ALL_ALT = 8'h01;
   localparam logic [7:0] ACK_ONE_XOR = 8'hFF;
   localparam logic [7:0] ACK_ONE_ALT = 8'hFE;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [COUNT_W-1:0] LEN_256    = 9'd256;
   localparam logic [POS_W-1:0]   POS_INS    = 3'd1;
   localparam logic [POS_W-1:0]   POS_P3     = 3'd4;
   localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(HEADER_BYTES - 1);

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_PROC     = 3'd1,
      PH_SW2      = 3'd2,
      PH_DATA_ALL = 3'd3,
      PH_DATA_ONE = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      ROLE_CLA     = 4'd0,
      ROLE_INS     = 4'd1,
      ROLE_P1      = 4'd2,
      ROLE_P2      = 4'd3,
      ROLE_P3      = 4'd4,
      ROLE_NULL    = 4'd5,
      ROLE_ACK_ALL = 4'd6,
      ROLE_ACK_ONE = 4'd7,
      ROLE_DATA    = 4'd8,
      ROLE_SW1     = 4'd9,
      ROLE_SW2     = 4'd10
   } role_type;

   typedef struct packed {
      phase_type          phase;
      logic [POS_W-1:0]   hdr_pos;
      logic [7:0]         ins;
      logic [7:0]         len;
      logic [COUNT_W-1:0] count;
      logic [7:0]         sw1;
      logic               card;
   } tracker_state_type;

   typedef struct packed {
      logic [3:0]  byte_role;
      logic        protocol_error;
      logic        transaction_done;
      logic        card_is_sender;
      logic [7:0]  command_ins;
      logic [15:0] status_word;
   } result_type;

endpackage

`default_nettype wire

>>> sv/t0_tpdu_byte_tracker.sv
// A byte accepted at one edge has its result valid right after that edge.
// Throughput: one byte per cycle; the labeling logic is a single pass from tracker state
// and the incoming byte into the result register, which also updates the tracker state.
// A new byte is taken while a result waits whenever the downstream side takes it that cycle.
// Reset (synchronous, active high): header phase, position and counters zero, reader sends,
// result register empty.
`default_nettype none

module t0_tpdu_byte_tracker
   import t0tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_line_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_byte_role,
   output logic        rsp_protocol_error,
   output logic        rsp_transaction_done,
   output logic        rsp_card_is_sender,
   output logic [7:0]  rsp_command_ins,
   output logic [15:0] rsp_status_word
);

   tracker_state_type state_ff;
   tracker_state_type state_in;
   result_type        result_ff;
   result_type        result_in;
   logic              rsp_valid_ff;
   logic              accept;

   // Take a byte whenever the result slot is empty or being drained this cycle.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   t0tb_step u_step (
      .cur_state  (state_ff),
      .line_byte  (req_line_byte),
      .next_state (state_in),
      .result     (result_in)
   );

   // Advance the tracker state only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= PH_HEADER;
         state_ff.hdr_pos <= '0;
         state_ff.ins     <= '0;
         state_ff.len     <= '0;
         state_ff.count   <= '0;
         state_ff.sw1     <= '0;
         state_ff.card    <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on accept, drop valid once the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset; hold it while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_byte_role        = result_ff.byte_role;
   assign rsp_protocol_error   = result_ff.protocol_error;
   assign rsp_transaction_done = result_ff.transaction_done;
   assign rsp_card_is_sender   = result_ff.card_is_sender;
   assign rsp_command_ins      = result_ff.command_ins;
   assign rsp_status_word      = result_ff.status_word;

endmodule

`default_nettype wire

>>> sv/t0tb_step.sv
// Next-state and labeling logic for one observed byte of a T=0 exchange.
// Depends on t0tb_pkg.
`default_nettype none

module t0tb_step
   import t0tb_pkg::*;
(
   input  tracker_state_type cur_state,
   input  logic [7:0]        line_byte,
   output tracker_state_type next_state,
   output result_type        result
);

   logic [POS_W-1:0]   pos;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] eff_len;
   logic               is_sw1;
   logic               is_ack_all;
   logic               is_ack_one;

   // header position wraps if it ever sits past the last header byte
   assign pos = (cur_state.phase == PH_HEADER && cur_state.hdr_pos <= POS_LAST) ?
                cur_state.hdr_pos : '0;
   assign count_inc = (cur_state.count == COUNT_MAX) ? COUNT_MAX : cur_state.count + 1'b1;
   assign eff_len = (cur_state.card && cur_state.len == 8'd0) ?
                    LEN_256 : {1'b0, cur_state.len};
   assign is_sw1 = ((line_byte & NIBBLE_MASK) == SW1_NIB_6) ||
                   ((line_byte & NIBBLE_MASK) == SW1_NIB_9);
   assign is_ack_all = (line_byte == cur_state.ins) ||
                       (line_byte == (cur_state.ins ^ ACK_ALL_ALT));
   assign is_ack_one = (line_byte == (cur_state.ins ^ ACK_ONE_XOR)) ||
                       (line_byte == (cur_state.ins ^ ACK_ONE_ALT));

   // next state
   always_comb begin
      next_state = cur_state;
      unique case (cur_state.phase)
         PH_PROC: begin
            if (line_byte == NULL_BYTE) begin
               next_state.phase = PH_PROC;
            end else if (is_sw1) begin
               next_state.sw1   = line_byte;
               next_state.phase = PH_SW2;
            end else if (is_ack_all) begin
               next_state.phase = PH_DATA_ALL;
            end else if (is_ack_one) begin
               next_state.phase = PH_DATA_ONE;
            end else begin
               next_state.card    = 1'b0;
               next_state.phase   = PH_HEADER;
               next_state.hdr_pos = '0;
               next_state.count   = '0;
            end
         end
         PH_SW2: begin
            next_state.card    = ~cur_state.card;
            next_state.phase   = PH_HEADER;
            next_state.hdr_pos = '0;
            next_state.count   = '0;
         end
         PH_DATA_ALL: begin
            next_state.count = count_inc;
            if (count_inc >= eff_len) begin
               next_state.phase = PH_PROC;
            end
         end
         PH_DATA_ONE: begin
            next_state.count = count_inc;
            next_state.phase = PH_PROC;
         end
         default: begin
            next_state.phase = PH_HEADER;
            if (pos == POS_INS) begin
               next_state.ins = line_byte;
            end
            if (pos == POS_P3) begin
               next_state.len = line_byte;
            end
            if (pos == POS_LAST) begin
               next_state.hdr_pos = '0;
               next_state.count   = '0;
               next_state.card    = ~cur_state.card;
               next_state.phase   = PH_PROC;
            end else begin
               next_state.hdr_pos = pos + 1'b1;
            end
         end
      endcase
   end

   // result fields
   always_comb begin
      result                  = '0;
      result.card_is_sender   = next_state.card;
      unique case (cur_state.phase)
         PH_PROC: begin
            if (line_byte == NULL_BYTE) begin
               result.byte_role = ROLE_NULL;
            end else if (is_sw1) begin
               result.byte_role = ROLE_SW1;
            end else if (is_ack_all) begin
               result.byte_role = ROLE_ACK_ALL;
            end else if (is_ack_one) begin
               result.byte_role = ROLE_ACK_ONE;
            end else begin
               result.protocol_error = 1'b1;
            end
         end
         PH_SW2: begin
            result.byte_role        = ROLE_SW2;
            result.transaction_done = 1'b1;
            result.command_ins      = cur_state.ins;
            result.status_word      = {cur_state.sw1, line_byte};
         end
         PH_DATA_ALL, PH_DATA_ONE: begin
            result.byte_role = ROLE_DATA;
         end
         default: begin
            result.byte_role = {1'b0, pos};
         end
      endcase
   end

endmodule

`default_nettype wire
